/* hdl/gamepad_report_conditioner_unit_defines.svh */
// ----------------------------------------------------------------------------
// gamepad report conditioner assertion macros
// concurrent check wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_REPORT_CONDITIONER_UNIT_DEFINES_SVH
`define GAMEPAD_REPORT_CONDITIONER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define GRC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gamepad conditioner check failed");
// expression must never be true outside reset
`define GRC_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("gamepad conditioner forbidden condition");
`else
`define GRC_ASSERT(label, clk, rst, prop)
`define GRC_NEVER(label, clk, rst, expr)
`endif
`endif

/* hdl/grc_pkg.sv */
// ----------------------------------------------------------------------------
// grc_pkg
// shared constants and datapath widths of the gamepad report conditioner
// ----------------------------------------------------------------------------
`default_nettype none

package grc_pkg;

  // full scale of a conditioned axis
  localparam int AXIS_MAX = 32000;

  // shift-add multiplier operand widths
  localparam int MUL_AW = 64;
  localparam int MUL_BW = 32;

  // restoring divider widths
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 50;
  localparam int DIV_QW = 24;

  // square root: radicand width, root width, fractional bits of the root
  localparam int SQ_NW   = 43;
  localparam int SQ_RW   = 38;
  localparam int SQ_FRAC = 16;

endpackage

`default_nettype wire

/* hdl/grc_mul.sv */
// ----------------------------------------------------------------------------
// grc_mul
// shift-add multiplier, one bit of b per cycle, stops when b runs out
// ----------------------------------------------------------------------------
`default_nettype none

module grc_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [grc_pkg::MUL_AW-1:0]  a,
  input  logic [grc_pkg::MUL_BW-1:0]  b,
  output logic                        busy,
  output logic [grc_pkg::MUL_AW-1:0]  p
);
  import grc_pkg::*;

  logic [MUL_AW-1:0] aa;
  logic [MUL_BW-1:0] bb;

  // busy while multiplier bits remain
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= (b != '0);
    end else if (busy) begin
      busy <= (bb[MUL_BW-1:1] != '0);
    end
  end

  // accumulate shifted multiplicand
  always_ff @(posedge clk) begin
    if (start) begin
      p  <= '0;
      aa <= a;
      bb <= b;
    end else if (busy) begin
      if (bb[0]) begin
        p <= p + aa;
      end
      aa <= aa << 1;
      bb <= bb >> 1;
    end
  end

endmodule

`default_nettype wire

/* hdl/grc_div.sv */
// ----------------------------------------------------------------------------
// grc_div
// restoring divider, one quotient bit per cycle, quotient known to be narrow
// ----------------------------------------------------------------------------
`default_nettype none

module grc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [grc_pkg::DIV_NW-1:0]  num,
  input  logic [grc_pkg::DIV_DW-1:0]  den,
  output logic                        busy,
  output logic [grc_pkg::DIV_QW-1:0]  q
);
  import grc_pkg::*;

  localparam int SH_W  = DIV_DW + DIV_QW - 1;
  localparam int CNT_W = $clog2(DIV_QW);

  logic [DIV_NW-1:0] rem;
  logic [SH_W-1:0]   dsh;
  logic [CNT_W-1:0]  cnt;
  logic              fits;

  // compare remainder against shifted divisor
  assign fits = ({{(SH_W-DIV_NW){1'b0}}, rem} >= dsh);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  // subtract and shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= {den, {(DIV_QW-1){1'b0}}};
      q   <= '0;
      cnt <= CNT_W'(DIV_QW-1);
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh[DIV_NW-1:0];
      end
      q   <= {q[DIV_QW-2:0], fits};
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* hdl/grc_sqrt.sv */
// ----------------------------------------------------------------------------
// grc_sqrt
// digit-by-digit square root of n with 16 fractional root bits, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module grc_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [grc_pkg::SQ_NW-1:0]   n,
  output logic                        busy,
  output logic [grc_pkg::SQ_RW-1:0]   root
);
  import grc_pkg::*;

  localparam int RAD_W = 2 * SQ_RW;
  localparam int REM_W = SQ_RW + 2;
  localparam int CNT_W = $clog2(SQ_RW);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [CNT_W-1:0] cnt;
  logic             take;

  // bring down next pair of radicand bits
  assign rem_sh = {rem[SQ_RW-1:0], rad[RAD_W-1:RAD_W-2]};
  assign trial  = {root, 2'b01};
  assign take   = (rem_sh >= trial);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  // trial subtract per root bit
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RAD_W'({n, {(2*SQ_FRAC){1'b0}}});
      rem  <= '0;
      root <= '0;
      cnt  <= CNT_W'(SQ_RW-1);
    end else if (busy) begin
      rem  <= take ? (rem_sh - trial) : rem_sh;
      root <= {root[SQ_RW-2:0], take};
      rad  <= rad << 2;
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* hdl/gamepad_report_conditioner_unit.sv */
// ----------------------------------------------------------------------------
// gamepad_report_conditioner_unit
// radial stick deadzone with rescale and clamp, trigger deadzone and scaling,
// trigger press, virtual direction keys, z axis and a button change flag
// ----------------------------------------------------------------------------
// processing time: shortest for sticks inside their zones and idle triggers,
//   longest for both sticks rescaled and clamped
// one report at a time: a new report is accepted only in idle, after the
//   last result is registered; the sequencer drives one shift-add multiplier,
//   one divider and one square root unit in turn, one operation at a time
// reset: synchronous, control and configuration registers to defaults, last packet all ones, no result
// ----------------------------------------------------------------------------
`default_nettype none
`include "gamepad_report_conditioner_unit_defines.svh"

module gamepad_report_conditioner_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        packet_number,
  input  logic signed [15:0] left_x,
  input  logic signed [15:0] left_y,
  input  logic signed [15:0] right_x,
  input  logic signed [15:0] right_y,
  input  logic [7:0]         left_trigger,
  input  logic [7:0]         right_trigger,
  input  logic [15:0]        button_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] stick_lx,
  output logic signed [15:0] stick_ly,
  output logic signed [15:0] stick_rx,
  output logic signed [15:0] stick_ry,
  output logic [14:0]        slider_left,
  output logic [14:0]        slider_right,
  output logic signed [15:0] z_axis,
  output logic [15:0]        buttons_out,
  output logic [1:0]         trigger_pressed,
  output logic [7:0]         virtual_dirs,
  output logic               buttons_changed,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);
  import grc_pkg::*;

  // register indexes
  localparam logic [1:0] REG_LEFT_DZ  = 2'd0;
  localparam logic [1:0] REG_RIGHT_DZ = 2'd1;
  localparam logic [1:0] REG_TRIG_THR = 2'd2;
  localparam logic [1:0] REG_VC_EN    = 2'd3;

  // sequencer states
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_STK_INIT = 5'd1;
  localparam logic [4:0] S_SQ_X     = 5'd2;
  localparam logic [4:0] S_SQ_XW    = 5'd3;
  localparam logic [4:0] S_SQ_Y     = 5'd4;
  localparam logic [4:0] S_SQ_YW    = 5'd5;
  localparam logic [4:0] S_DZ_SQ    = 5'd6;
  localparam logic [4:0] S_DZ_SQW   = 5'd7;
  localparam logic [4:0] S_RT       = 5'd8;
  localparam logic [4:0] S_RT_W     = 5'd9;
  localparam logic [4:0] S_SPAN     = 5'd10;
  localparam logic [4:0] S_SPAN_W   = 5'd11;
  localparam logic [4:0] S_DEN      = 5'd12;
  localparam logic [4:0] S_DEN_W    = 5'd13;
  localparam logic [4:0] S_SC_MUL   = 5'd14;
  localparam logic [4:0] S_SC_MW    = 5'd15;
  localparam logic [4:0] S_SC_DW    = 5'd16;
  localparam logic [4:0] S_STK_END  = 5'd17;
  localparam logic [4:0] S_TR_INIT  = 5'd18;
  localparam logic [4:0] S_TR_D1W   = 5'd19;
  localparam logic [4:0] S_TR_MW    = 5'd20;
  localparam logic [4:0] S_TR_D2W   = 5'd21;
  localparam logic [4:0] S_TR_NEXT  = 5'd22;
  localparam logic [4:0] S_FIN      = 5'd23;

  localparam int VAL_W = 22;
  localparam int D2_W  = SQ_NW;

  localparam logic [14:0] RST_LEFT_DZ  = 15'd7849;
  localparam logic [14:0] RST_RIGHT_DZ = 15'd8689;
  localparam logic [7:0]  RST_TRIG_THR = 8'd30;
  localparam logic [14:0] DZ_MAX       = 15'(AXIS_MAX - 1000);
  localparam logic [D2_W-1:0] CLAMP_SQ = D2_W'(AXIS_MAX * AXIS_MAX);
  localparam logic [DIV_QW-1:0] Q_MAX  = DIV_QW'(AXIS_MAX);
  localparam logic signed [VAL_W-1:0] VAL_MAX = VAL_W'(AXIS_MAX);
  localparam logic signed [VAL_W-1:0] VAL_MIN = -VAL_MAX;
  localparam logic [7:0]  PRESS_MIN    = 8'd36;
  localparam logic [7:0]  TRIG_FULL    = 8'd255;
  localparam logic signed [15:0] DIR_LEVEL = 16'sd16384;

  // direction keys of one stick: right, left, up, down
  function automatic logic [3:0] dir_bits(input logic signed [15:0] h,
                                          input logic signed [15:0] v);
    logic [3:0] b;
    b = '0;
    if (h >= DIR_LEVEL) begin
      b[0] = 1'b1;
    end else if (h <= -DIR_LEVEL) begin
      b[1] = 1'b1;
    end
    if (v >= DIR_LEVEL) begin
      b[2] = 1'b1;
    end else if (v <= -DIR_LEVEL) begin
      b[3] = 1'b1;
    end
    return b;
  endfunction

  // control state
  logic [4:0]  state;
  logic [31:0] last_packet;
  logic [25:0] prev_set;
  logic signed [16:0] held_z;
  logic [14:0] left_dz;
  logic [14:0] right_dz;
  logic [7:0]  thr;
  logic        vc_en;
  logic        stk;
  logic        phase;
  logic        comp;
  logic        trg;

  // datapath registers
  logic signed [15:0] lx_r, ly_r, rx_r, ry_r;
  logic [7:0]  lt_r, rt_r;
  logic [15:0] btn_r;
  logic signed [VAL_W-1:0] vx, vy;
  logic [D2_W-1:0]   d2;
  logic [14:0]       dzr;
  logic [SQ_RW-1:0]  dq;
  logic [MUL_AW-1:0] mulv;
  logic [DIV_DW-1:0] den;
  logic signed [15:0] sx, sy, tx, ty;
  logic [14:0] sl, sr;

  // shared unit hookup
  logic              mul_start, mul_busy;
  logic [MUL_AW-1:0] mul_a, mul_p;
  logic [MUL_BW-1:0] mul_b;
  logic              div_start, div_busy;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_QW-1:0] div_q;
  logic              sq_start, sq_busy;
  logic [SQ_RW-1:0]  sq_root;

  // derived values
  logic [14:0]       dz_raw, dz_eff;
  logic [VAL_W-1:0]  mag_x, mag_y, mag_c;
  logic [D2_W-1:0]   d2_sum;
  logic [DIV_QW-1:0] sc_q_lim;
  logic [VAL_W-1:0]  sc_mag;
  logic              sc_neg;
  logic signed [VAL_W-1:0] sc_val;
  logic [7:0]  trig_v, trig_d;
  logic [1:0]  pressed;
  logic [7:0]  dirs;
  logic signed [16:0] z_new;
  logic [25:0] set_now;
  logic        in_fire;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // effective stick deadzone
  assign dz_raw = stk ? right_dz : left_dz;
  assign dz_eff = (dz_raw > DZ_MAX) ? DZ_MAX : dz_raw;

  // magnitudes of the working vector
  assign mag_x = vx[VAL_W-1] ? VAL_W'(-vx) : VAL_W'(vx);
  assign mag_y = vy[VAL_W-1] ? VAL_W'(-vy) : VAL_W'(vy);
  assign mag_c = comp ? mag_y : mag_x;
  assign d2_sum = d2 + mul_p[D2_W-1:0];

  // rounded component with sign restored, clamped in the circle pass
  assign sc_q_lim = (phase && div_q > Q_MAX) ? Q_MAX : div_q;
  assign sc_mag   = VAL_W'(sc_q_lim);
  assign sc_neg   = comp ? vy[VAL_W-1] : vx[VAL_W-1];
  assign sc_val   = sc_neg ? -$signed(sc_mag) : $signed(sc_mag);

  // trigger operands
  assign trig_v = trg ? rt_r : lt_r;
  assign trig_d = trig_v - thr;

  // digital set of the report
  assign pressed[0] = (lt_r >= PRESS_MIN) && (lt_r > thr);
  assign pressed[1] = (rt_r >= PRESS_MIN) && (rt_r > thr);
  assign dirs  = vc_en ? {dir_bits(rx_r, ry_r), dir_bits(lx_r, ly_r)} : 8'h00;
  assign z_new = vc_en ? ($signed({2'b00, sr}) - $signed({2'b00, sl})) : held_z;
  assign set_now = {dirs, pressed, btn_r};

  // unit start and operand selection
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    unique case (state)
      S_SQ_X: begin
        mul_start = 1'b1;
        mul_a     = MUL_AW'(mag_x);
        mul_b     = MUL_BW'(mag_x);
      end
      S_SQ_Y: begin
        mul_start = 1'b1;
        mul_a     = MUL_AW'(mag_y);
        mul_b     = MUL_BW'(mag_y);
      end
      S_DZ_SQ: begin
        mul_start = 1'b1;
        mul_a     = MUL_AW'(dzr);
        mul_b     = MUL_BW'(dzr);
      end
      S_RT: begin
        sq_start = 1'b1;
      end
      S_SPAN: begin
        mul_start = 1'b1;
        mul_a     = MUL_AW'(dq) - (MUL_AW'(dzr) << SQ_FRAC);
        mul_b     = MUL_BW'(AXIS_MAX);
      end
      S_DEN: begin
        mul_start = 1'b1;
        mul_a     = MUL_AW'(dq);
        mul_b     = MUL_BW'(AXIS_MAX) - MUL_BW'(dzr);
      end
      S_SC_MUL: begin
        mul_start = 1'b1;
        mul_a     = mulv;
        mul_b     = MUL_BW'({mag_c, 1'b0});
      end
      S_SC_MW: begin
        div_start = !mul_busy;
        div_num   = mul_p + DIV_NW'(den);
        div_den   = {den[DIV_DW-2:0], 1'b0};
      end
      S_TR_INIT: begin
        div_start = (trig_v > thr);
        div_num   = DIV_NW'({trig_d, 8'h00}) - DIV_NW'(trig_d);
        div_den   = DIV_DW'(TRIG_FULL - thr);
      end
      S_TR_D1W: begin
        mul_start = !div_busy;
        mul_a     = MUL_AW'(div_q);
        mul_b     = MUL_BW'(2 * AXIS_MAX);
      end
      S_TR_MW: begin
        div_start = !mul_busy;
        div_num   = mul_p + DIV_NW'(TRIG_FULL);
        div_den   = DIV_DW'(2 * TRIG_FULL);
      end
      default: begin
      end
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      last_packet <= '1;
      prev_set    <= '0;
      held_z      <= '0;
      left_dz     <= RST_LEFT_DZ;
      right_dz    <= RST_RIGHT_DZ;
      thr         <= RST_TRIG_THR;
      vc_en       <= 1'b1;
      out_valid   <= 1'b0;
      stk         <= 1'b0;
      phase       <= 1'b0;
      comp        <= 1'b0;
      trg         <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LEFT_DZ:  left_dz  <= cfg_data;
          REG_RIGHT_DZ: right_dz <= cfg_data;
          REG_TRIG_THR: thr      <= cfg_data[7:0];
          REG_VC_EN:    vc_en    <= cfg_data[0];
        endcase
      end

      // result transfer
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire && packet_number != last_packet) begin
            last_packet <= packet_number;
            lx_r  <= left_x;
            ly_r  <= left_y;
            rx_r  <= right_x;
            ry_r  <= right_y;
            lt_r  <= left_trigger;
            rt_r  <= right_trigger;
            btn_r <= button_word;
            stk   <= 1'b0;
            state <= S_STK_INIT;
          end
        end
        S_STK_INIT: begin
          vx    <= VAL_W'(stk ? rx_r : lx_r);
          vy    <= VAL_W'(stk ? ry_r : ly_r);
          dzr   <= dz_eff;
          phase <= (dz_eff == '0);
          state <= S_SQ_X;
        end
        S_SQ_X: state <= S_SQ_XW;
        S_SQ_XW: begin
          if (!mul_busy) begin
            d2    <= mul_p[D2_W-1:0];
            state <= S_SQ_Y;
          end
        end
        S_SQ_Y: state <= S_SQ_YW;
        S_SQ_YW: begin
          if (!mul_busy) begin
            d2 <= d2_sum;
            if (!phase) begin
              state <= S_DZ_SQ;
            end else if (d2_sum > CLAMP_SQ) begin
              state <= S_RT;
            end else begin
              state <= S_STK_END;
            end
          end
        end
        S_DZ_SQ: state <= S_DZ_SQW;
        S_DZ_SQW: begin
          if (!mul_busy) begin
            if (d2 < mul_p[D2_W-1:0]) begin
              vx    <= '0;
              vy    <= '0;
              state <= S_STK_END;
            end else begin
              state <= S_RT;
            end
          end
        end
        S_RT: state <= S_RT_W;
        S_RT_W: begin
          if (!sq_busy) begin
            dq <= sq_root;
            if (!phase) begin
              state <= S_SPAN;
            end else begin
              mulv  <= MUL_AW'(AXIS_MAX) << SQ_FRAC;
              den   <= DIV_DW'(sq_root);
              comp  <= 1'b0;
              state <= S_SC_MUL;
            end
          end
        end
        S_SPAN: state <= S_SPAN_W;
        S_SPAN_W: begin
          if (!mul_busy) begin
            mulv  <= mul_p;
            state <= S_DEN;
          end
        end
        S_DEN: state <= S_DEN_W;
        S_DEN_W: begin
          if (!mul_busy) begin
            den   <= mul_p[DIV_DW-1:0];
            comp  <= 1'b0;
            state <= S_SC_MUL;
          end
        end
        S_SC_MUL: state <= S_SC_MW;
        S_SC_MW: begin
          if (!mul_busy) begin
            state <= S_SC_DW;
          end
        end
        S_SC_DW: begin
          if (!div_busy) begin
            if (comp) begin
              vy <= sc_val;
            end else begin
              vx <= sc_val;
            end
            if (!comp) begin
              comp  <= 1'b1;
              state <= S_SC_MUL;
            end else if (!phase) begin
              phase <= 1'b1;
              state <= S_SQ_X;
            end else begin
              state <= S_STK_END;
            end
          end
        end
        S_STK_END: begin
          if (!stk) begin
            sx    <= vx[15:0];
            sy    <= vy[15:0];
            stk   <= 1'b1;
            state <= S_STK_INIT;
          end else begin
            tx    <= vx[15:0];
            ty    <= vy[15:0];
            trg   <= 1'b0;
            state <= S_TR_INIT;
          end
        end
        S_TR_INIT: begin
          if (trig_v > thr) begin
            state <= S_TR_D1W;
          end else begin
            if (trg) begin
              sr <= '0;
            end else begin
              sl <= '0;
            end
            state <= S_TR_NEXT;
          end
        end
        S_TR_D1W: begin
          if (!div_busy) begin
            state <= S_TR_MW;
          end
        end
        S_TR_MW: begin
          if (!mul_busy) begin
            state <= S_TR_D2W;
          end
        end
        S_TR_D2W: begin
          if (!div_busy) begin
            if (trg) begin
              sr <= div_q[14:0];
            end else begin
              sl <= div_q[14:0];
            end
            state <= S_TR_NEXT;
          end
        end
        S_TR_NEXT: begin
          if (!trg) begin
            trg   <= 1'b1;
            state <= S_TR_INIT;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            stick_lx        <= sx;
            stick_ly        <= sy;
            stick_rx        <= tx;
            stick_ry        <= ty;
            slider_left     <= sl;
            slider_right    <= sr;
            z_axis          <= z_new[15:0];
            buttons_out     <= btn_r;
            trigger_pressed <= pressed;
            virtual_dirs    <= dirs;
            buttons_changed <= (set_now != prev_set);
            held_z          <= z_new;
            prev_set        <= set_now;
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // shared arithmetic units
  grc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .p     (mul_p)
  );

  grc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .q     (div_q)
  );

  grc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .n     (d2),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  // checks
  `GRC_NEVER(a_one_unit_busy, clk, rst, ($countones({mul_busy, div_busy, sq_busy}) > 1))
  `GRC_ASSERT(a_idle_units_quiet, clk, rst, in_ready |-> !(mul_busy || div_busy || sq_busy))
  `GRC_ASSERT(a_repeat_dropped, clk, rst, (in_fire && packet_number == last_packet) |=> (state == S_IDLE))
  `GRC_ASSERT(a_stick_in_circle, clk, rst, (state == S_STK_END) |-> (vx <= VAL_MAX && vx >= VAL_MIN && vy <= VAL_MAX && vy >= VAL_MIN))

endmodule

`default_nettype wire
